/* sv/grid_maze_route_walker_top_defines.svh */
// Assertion macros for the grid maze route walker.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef GRID_MAZE_ROUTE_WALKER_TOP_DEFINES_SVH
`define GRID_MAZE_ROUTE_WALKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GMRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GMRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gmrw_pkg.sv */
// Shared types, constants and the microcode program of the maze walker.
// No dependencies; imported by every module of the block.
package gmrw_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int POS_W    = 4;
  localparam int SIZE_W   = 5;
  localparam int STEP_W   = 9;
  localparam int UPC_W    = 5;
  localparam int IDX_W    = 3;
  localparam int INS_W    = 8;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef logic [CELL_AW-1:0] cell_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [UPC_W-1:0]   upc_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [IDX_W-1:0] {
    REG_HEIGHT    = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_START_ROW = 3'd2,
    REG_START_COL = 3'd3,
    REG_GOAL_ROW  = 3'd4,
    REG_GOAL_COL  = 3'd5
  } reg_e;

  // Datapath operations selected by one control word.
  typedef enum logic [3:0] {
    A_NOP,
    A_WALL_WR,
    A_RES_ZERO,
    A_MARK_RD,
    A_RES_READ,
    A_RUN_INIT,
    A_MARK_START,
    A_D_CLEAR,
    A_PROBE,
    A_D_INC,
    A_MARK_DEAD,
    A_ADVANCE,
    A_RETREAT,
    A_RES_RUN
  } act_e;

  // Jump conditions; C_NEXT never jumps.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_OP_WRITE,
    C_OP_RUN,
    C_OP_READ,
    C_START_OUT,
    C_AT_GOAL,
    C_FRESH,
    C_ESCAPE,
    C_D_NOT_LAST
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  tgt;
  } uword_t;

  // Control word handed to the datapath each cycle.
  typedef struct packed {
    act_e act;
    logic accept;
  } ctrl_t;

  // Status flags that the sequencer branches on.
  typedef struct packed {
    logic slot_free;
    logic op_write;
    logic op_run;
    logic op_read;
    logic start_out;
    logic at_goal;
    logic fresh;
    logic escape;
    logic d_last;
  } stat_t;

  typedef struct packed {
    logic  dead;
    step_t step;
  } mark_t;

  // Program addresses.
  localparam upc_t UA_IDLE     = 5'd0;
  localparam upc_t UA_DISP_WR  = 5'd1;
  localparam upc_t UA_DISP_RUN = 5'd2;
  localparam upc_t UA_DISP_RD  = 5'd3;
  localparam upc_t UA_ZERO     = 5'd4;
  localparam upc_t UA_WR       = 5'd5;
  localparam upc_t UA_RD       = 5'd6;
  localparam upc_t UA_RD_OUT   = 5'd7;
  localparam upc_t UA_RUN      = 5'd8;
  localparam upc_t UA_MARK0    = 5'd9;
  localparam upc_t UA_LOOP     = 5'd10;
  localparam upc_t UA_P1_PROBE = 5'd11;
  localparam upc_t UA_P1_TEST  = 5'd12;
  localparam upc_t UA_P1_NEXT  = 5'd13;
  localparam upc_t UA_DEAD     = 5'd14;
  localparam upc_t UA_P2_PROBE = 5'd15;
  localparam upc_t UA_P2_TEST  = 5'd16;
  localparam upc_t UA_P2_NEXT  = 5'd17;
  localparam upc_t UA_FINISH   = 5'd18;
  localparam upc_t UA_ADVANCE  = 5'd19;
  localparam upc_t UA_RETREAT  = 5'd20;

  // The walk program. A taken condition jumps to tgt, otherwise the step
  // counter moves on by one.
  function automatic uword_t ucode_rom(upc_t upc);
    uword_t w;
    unique case (upc)
      UA_IDLE:     w = '{A_NOP,        C_NO_ITEM,    UA_IDLE};
      UA_DISP_WR:  w = '{A_NOP,        C_OP_WRITE,   UA_WR};
      UA_DISP_RUN: w = '{A_NOP,        C_OP_RUN,     UA_RUN};
      UA_DISP_RD:  w = '{A_NOP,        C_OP_READ,    UA_RD};
      UA_ZERO:     w = '{A_RES_ZERO,   C_ALWAYS,     UA_IDLE};
      UA_WR:       w = '{A_WALL_WR,    C_ALWAYS,     UA_IDLE};
      UA_RD:       w = '{A_MARK_RD,    C_NEXT,       UA_IDLE};
      UA_RD_OUT:   w = '{A_RES_READ,   C_ALWAYS,     UA_IDLE};
      UA_RUN:      w = '{A_RUN_INIT,   C_START_OUT,  UA_ZERO};
      UA_MARK0:    w = '{A_MARK_START, C_NEXT,       UA_IDLE};
      UA_LOOP:     w = '{A_D_CLEAR,    C_AT_GOAL,    UA_FINISH};
      UA_P1_PROBE: w = '{A_PROBE,      C_NEXT,       UA_IDLE};
      UA_P1_TEST:  w = '{A_NOP,        C_FRESH,      UA_ADVANCE};
      UA_P1_NEXT:  w = '{A_D_INC,      C_D_NOT_LAST, UA_P1_PROBE};
      UA_DEAD:     w = '{A_MARK_DEAD,  C_NEXT,       UA_IDLE};
      UA_P2_PROBE: w = '{A_PROBE,      C_NEXT,       UA_IDLE};
      UA_P2_TEST:  w = '{A_NOP,        C_ESCAPE,     UA_RETREAT};
      UA_P2_NEXT:  w = '{A_D_INC,      C_D_NOT_LAST, UA_P2_PROBE};
      UA_FINISH:   w = '{A_RES_RUN,    C_ALWAYS,     UA_IDLE};
      UA_ADVANCE:  w = '{A_ADVANCE,    C_ALWAYS,     UA_LOOP};
      UA_RETREAT:  w = '{A_RETREAT,    C_ALWAYS,     UA_LOOP};
      default:     w = '{A_NOP,        C_ALWAYS,     UA_IDLE};
    endcase
    return w;
  endfunction

  function automatic cell_t cell_addr(pos_t r, pos_t c);
    return CELL_AW'(r) * CELL_AW'(MAX_COLS) + CELL_AW'(c);
  endfunction

  // A size of zero counts as one, anything above the maximum as the maximum.
  function automatic size_t clamp_size(size_t v, size_t max);
    size_t res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > max) begin
      res = max;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

/* sv/gmrw_seq.sv */
// Microcode sequencer of the maze walker: step counter, program lookup
// and jump logic. Depends on gmrw_pkg.
module gmrw_seq import gmrw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   accept;
  logic   take;

  assign uw         = ucode_rom(upc_q);
  assign in_ready_o = (upc_q == UA_IDLE) && stat_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = !accept;
      C_OP_WRITE:   take = stat_i.op_write;
      C_OP_RUN:     take = stat_i.op_run;
      C_OP_READ:    take = stat_i.op_read;
      C_START_OUT:  take = stat_i.start_out;
      C_AT_GOAL:    take = stat_i.at_goal;
      C_FRESH:      take = stat_i.fresh;
      C_ESCAPE:     take = stat_i.escape;
      C_D_NOT_LAST: take = !stat_i.d_last;
      default:      take = 1'b0;
    endcase
    upc_d = take ? uw.tgt : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.act    = uw.act;
  assign ctrl_o.accept = accept;

endmodule

/* sv/gmrw_datapath.sv */
// Datapath of the maze walker: configuration, wall and mark memories,
// walker position, step register and result register. Depends on gmrw_pkg.
module gmrw_datapath import gmrw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  size_t            cfg_data_i,
  input  logic [1:0]       op_i,
  input  pos_t             row_i,
  input  pos_t             col_i,
  input  logic [1:0]       walls_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output step_t            step_number_o,
  output logic             dead_end_o,
  output logic             reached_goal_o
);

  // Configuration registers.
  size_t height_q, width_q;
  pos_t  start_row_q, start_col_q, goal_row_q, goal_col_q;

  // Captured input word.
  op_e        op_q;
  pos_t       row_q, col_q;
  logic [1:0] walls_q;

  // Walker state.
  pos_t  r_q, c_q, nr_q, nc_q;
  step_t step_q;
  dir_e  dir_q;
  logic  nb_in_q;

  // Memories.
  logic [1:0]       wall_mem [CELLS];
  logic [1:0]       wall_rd_q;
  mark_t            mark_mem [CELLS];
  mark_t            mark_rd_q;
  logic [CELLS-1:0] mark_vld_q;
  logic             mark_rd_vld_q;

  // Result register.
  logic  out_valid_q;
  step_t res_step_q;
  logic  res_dead_q, res_goal_q;

  size_t h, w;
  pos_t  nr, nc;
  logic  nb_in;
  cell_t wall_ra, mark_ra, mark_wa, io_cell;
  mark_t mark_wd;
  logic  mark_we, mark_re;
  logic  io_inside, open, visited, is_dead, at_goal, start_in;
  step_t step_inc;

  assign h        = clamp_size(height_q, SIZE_W'(MAX_ROWS));
  assign w        = clamp_size(width_q, SIZE_W'(MAX_COLS));
  assign start_in = (SIZE_W'(start_row_q) < h) && (SIZE_W'(start_col_q) < w);
  assign at_goal  = (r_q == goal_row_q) && (c_q == goal_col_q);
  assign io_cell  = cell_addr(row_q, col_q);
  assign io_inside = (INS_W'(row_q) < INS_W'(MAX_ROWS)) && (INS_W'(col_q) < INS_W'(MAX_COLS));
  assign step_inc = (step_q == STEP_MAX) ? STEP_MAX : step_q + STEP_W'(1);

  // Neighbour in the current direction, its bounds check, and the cell
  // whose wall bits separate it from the walker.
  always_comb begin
    nr      = r_q;
    nc      = c_q;
    nb_in   = 1'b0;
    wall_ra = cell_addr(r_q, c_q);
    unique case (dir_q)
      DIR_LEFT: begin
        nc      = c_q - POS_W'(1);
        nb_in   = (c_q != '0);
        wall_ra = cell_addr(r_q, nc);
      end
      DIR_UP: begin
        nr      = r_q - POS_W'(1);
        nb_in   = (r_q != '0);
        wall_ra = cell_addr(nr, c_q);
      end
      DIR_RIGHT: begin
        nc    = c_q + POS_W'(1);
        nb_in = (SIZE_W'(c_q) + SIZE_W'(1)) < w;
      end
      default: begin
        nr    = r_q + POS_W'(1);
        nb_in = (SIZE_W'(r_q) + SIZE_W'(1)) < h;
      end
    endcase
  end

  // Up and down probes look at the wall-below bit, left and right at the
  // wall-right bit.
  assign open    = nb_in_q && !(dir_q[0] ? wall_rd_q[1] : wall_rd_q[0]);
  assign visited = mark_rd_vld_q && (mark_rd_q.step != '0);
  assign is_dead = mark_rd_vld_q && mark_rd_q.dead;

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.op_write  = (op_q == OP_WRITE);
  assign stat_o.op_run    = (op_q == OP_RUN);
  assign stat_o.op_read   = (op_q == OP_READ);
  assign stat_o.start_out = !start_in;
  assign stat_o.at_goal   = at_goal;
  assign stat_o.fresh     = open && !visited;
  assign stat_o.escape    = open && !is_dead;
  assign stat_o.d_last    = (dir_q == DIR_DOWN);

  // Mark memory port control.
  always_comb begin
    mark_we = 1'b0;
    mark_wa = cell_addr(r_q, c_q);
    mark_wd = '{dead: 1'b0, step: step_q};
    mark_re = 1'b0;
    mark_ra = io_cell;
    unique case (ctrl_i.act)
      A_MARK_START: begin
        mark_we = 1'b1;
        mark_wd = '{dead: 1'b0, step: STEP_W'(1)};
      end
      A_MARK_DEAD: begin
        mark_we = 1'b1;
        mark_wd = '{dead: 1'b1, step: step_q};
      end
      A_ADVANCE: begin
        mark_we = 1'b1;
        mark_wa = cell_addr(nr_q, nc_q);
        mark_wd = '{dead: 1'b0, step: step_inc};
      end
      A_MARK_RD: mark_re = 1'b1;
      A_PROBE: begin
        mark_re = 1'b1;
        mark_ra = cell_addr(nr, nc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == A_WALL_WR && io_inside) begin
      wall_mem[io_cell] <= walls_q;
    end
    if (ctrl_i.act == A_PROBE) begin
      wall_rd_q <= wall_mem[wall_ra];
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_ra];
    end
  end

  // Valid bits stand in for clearing the mark memory on every run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_vld_q    <= '0;
      mark_rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.act == A_RUN_INIT) begin
        mark_vld_q <= '0;
      end else if (mark_we) begin
        mark_vld_q[mark_wa] <= 1'b1;
      end
      if (mark_re) begin
        mark_rd_vld_q <= mark_vld_q[mark_ra];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= SIZE_W'(MAX_ROWS);
      width_q     <= SIZE_W'(MAX_COLS);
      start_row_q <= '0;
      start_col_q <= '0;
      goal_row_q  <= '1;
      goal_col_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEIGHT:    height_q    <= cfg_data_i;
        REG_WIDTH:     width_q     <= cfg_data_i;
        REG_START_ROW: start_row_q <= cfg_data_i[POS_W-1:0];
        REG_START_COL: start_col_q <= cfg_data_i[POS_W-1:0];
        REG_GOAL_ROW:  goal_row_q  <= cfg_data_i[POS_W-1:0];
        REG_GOAL_COL:  goal_col_q  <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else if (ctrl_i.accept) begin
      op_q <= op_e'(op_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      row_q   <= row_i;
      col_q   <= col_i;
      walls_q <= walls_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      c_q    <= '0;
      step_q <= '0;
      dir_q  <= DIR_LEFT;
    end else begin
      unique case (ctrl_i.act)
        A_RUN_INIT: begin
          if (start_in) begin
            r_q    <= start_row_q;
            c_q    <= start_col_q;
            step_q <= STEP_W'(1);
          end
        end
        A_D_CLEAR: dir_q <= DIR_LEFT;
        A_D_INC:   dir_q <= dir_e'(dir_q + 2'd1);
        A_ADVANCE: begin
          r_q    <= nr_q;
          c_q    <= nc_q;
          step_q <= step_inc;
        end
        A_RETREAT: begin
          r_q    <= nr_q;
          c_q    <= nc_q;
          step_q <= mark_rd_vld_q ? mark_rd_q.step : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == A_PROBE) begin
      nr_q    <= nr;
      nc_q    <= nc;
      nb_in_q <= nb_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.act == A_WALL_WR || ctrl_i.act == A_RES_ZERO ||
                 ctrl_i.act == A_RES_READ || ctrl_i.act == A_RES_RUN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.act)
      A_WALL_WR, A_RES_ZERO: begin
        res_step_q <= '0;
        res_dead_q <= 1'b0;
        res_goal_q <= 1'b0;
      end
      A_RES_READ: begin
        res_step_q <= (io_inside && mark_rd_vld_q) ? mark_rd_q.step : '0;
        res_dead_q <= io_inside && mark_rd_vld_q && mark_rd_q.dead;
        res_goal_q <= 1'b0;
      end
      A_RES_RUN: begin
        res_step_q <= step_q;
        res_dead_q <= 1'b0;
        res_goal_q <= at_goal;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign step_number_o  = res_step_q;
  assign dead_end_o     = res_dead_q;
  assign reached_goal_o = res_goal_q;

endmodule

/* sv/grid_maze_route_walker_top.sv */
// Top level of the grid maze route walker: sequencer plus datapath.
// Depends on gmrw_pkg, gmrw_seq, gmrw_datapath and the defines header.
`include "grid_maze_route_walker_top_defines.svh"

// The block holds a 16 by 16 maze of wall bits and walks it depth first
// from a start cell toward a goal cell. Every input word gives exactly one
// result word. A run sets up the walker and marks the start cell, then at
// each visited position checks for the goal and, for each direction in
// turn, reads the memories for that neighbour, tests the probe and steps the
// direction, until a probe succeeds and the walker moves; a position whose
// forward probes all fail is marked a dead end and probes again for an open
// neighbour that is not a dead end, to back into. The result register is
// loaded last. The run time is set by the microcoded sequencer, which
// probes one neighbour at a time through the single read port of the wall
// memory and of the mark memory. Step and dead-end marks are cleared at the
// start of each run through one valid bit per cell. The block takes one
// word at a time; in_ready_o is high only while it is idle and the result
// register is empty or being emptied, and a finished result waits in that
// register until taken. Configuration writes must be made while the block
// is idle.
module grid_maze_route_walker_top import gmrw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [4:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [3:0]       row_i,
  input  logic [3:0]       col_i,
  input  logic [1:0]       walls_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [8:0]       step_number_o,
  output logic             dead_end_o,
  output logic             reached_goal_o
);

  ctrl_t ctrl;
  stat_t stat;

  // The sequencer steps through the walk program and branches on status.
  gmrw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the maze, the marks and the walker position.
  gmrw_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .walls_i        (walls_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_number_o  (step_number_o),
    .dead_end_o     (dead_end_o),
    .reached_goal_o (reached_goal_o)
  );

  // Only one word is in work at a time.
  `GMRW_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "accepted a word while busy")
  // A result appears only out of a busy cycle, never straight from idle.
  `GMRW_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(!in_ready_o), "result without work")
  // A result never claims both a dead end and a reached goal.
  `GMRW_ASSERT_NOW(a_result_fields, out_valid_o, !(dead_end_o && reached_goal_o), "mixed result fields")

endmodule

/* tb/tb_top.sv */
// Testbench for grid_maze_route_walker_top: wall writes, depth-first walks and mark reads
// under random handshake stalls, each result word checked against a local walk model.
// Depends on gmrw_pkg and the RTL of the block; nothing else.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gmrw_pkg::*;

  // Stimulus stops once this many words have been accepted.
  localparam int WORD_TARGET = 650;
  // Even if every run of the test walked a full 16 by 16 maze, the couple of
  // hundred runs would stay several times below this limit.
  localparam int CYCLE_LIMIT = 10_000_000;

  // One result word as the block reports it.
  typedef struct packed {
    step_t step;
    logic  dead;
    logic  goal;
  } answer_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i   = '0;
  logic [4:0]       cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [1:0]       op_i        = '0;
  logic [3:0]       row_i       = '0;
  logic [3:0]       col_i       = '0;
  logic [1:0]       walls_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b1;
  logic [8:0]       step_number_o;
  logic             dead_end_o;
  logic             reached_goal_o;

  grid_maze_route_walker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .walls_i        (walls_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_number_o  (step_number_o),
    .dead_end_o     (dead_end_o),
    .reached_goal_o (reached_goal_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the block's state. The wall store of the block is undefined
  // until written, so wall_known tracks which cells a walk may safely use.
  logic [1:0] wall_mem   [CELLS] = '{default: '0};
  step_t      visit_mark [CELLS] = '{default: '0};
  logic       dead_mark  [CELLS] = '{default: 1'b0};
  bit         wall_known [CELLS] = '{default: 1'b0};
  pos_t       walker_row_m = '0;
  pos_t       walker_col_m = '0;

  // Local copy of the configuration registers, at their reset values.
  int rows_cfg = 16;
  int cols_cfg = 16;
  int start_row_cfg = 0;
  int start_col_cfg = 0;
  int goal_row_cfg = 15;
  int goal_col_cfg = 15;

  // Answers owed by the block, oldest first.
  answer_t answers_due[$];

  int words_sent = 0;
  int fail_count = 0;
  int cycles     = 0;
  int stall_left = 0;

  // Idling pressure: odds out of ten of starting a burst of idling.
  // Set per phase; zero gives stretches with no idling at all. Once calm is
  // set, neither side idles again.
  int gap_odds   = 2;
  int stall_odds = 2;
  bit calm       = 1'b0;

  function automatic int cell_index(int r, int c);
    return r * MAX_COLS + c;
  endfunction

  // Sizes of zero count as one and anything above the maximum as the maximum.
  function automatic int clamp_dim(int v, int max);
    if (v < 1) return 1;
    if (v > max) return max;
    return v;
  endfunction

  // A passage out of a cell is open when it stays inside the maze and the
  // wall bit between the two cells is clear. Left and up use the neighbor's
  // right and down walls.
  function automatic bit passage_open(int r, int c, dir_e d, int h, int w);
    bit open_way;
    case (d)
      DIR_LEFT:  open_way = c > 0 && !wall_mem[cell_index(r, c - 1)][0];
      DIR_UP:    open_way = r > 0 && !wall_mem[cell_index(r - 1, c)][1];
      DIR_RIGHT: open_way = c + 1 < w && !wall_mem[cell_index(r, c)][0];
      default:   open_way = r + 1 < h && !wall_mem[cell_index(r, c)][1];
    endcase
    return open_way;
  endfunction

  function automatic void step_toward(int r, int c, dir_e d, output int nr, output int nc);
    nr = r;
    nc = c;
    case (d)
      DIR_LEFT:  nc = c - 1;
      DIR_UP:    nr = r - 1;
      DIR_RIGHT: nc = c + 1;
      default:   nr = r + 1;
    endcase
  endfunction

  // Depth-first walk from the start cell. Forward moves go to the first open,
  // unvisited neighbor and number it; when there is none the cell becomes a
  // dead end and the walker backs into the first open neighbor that is not one.
  function automatic answer_t walk_toward_goal();
    answer_t a;
    int h, w, r, c, nr, nc, d, guard;
    bit moved;
    a = '0;
    h = clamp_dim(rows_cfg, MAX_ROWS);
    w = clamp_dim(cols_cfg, MAX_COLS);
    for (int i = 0; i < CELLS; i++) begin
      visit_mark[i] = '0;
      dead_mark[i]  = 1'b0;
    end
    // A start outside the maze marks nothing and leaves the walker alone.
    if (start_row_cfg >= h || start_col_cfg >= w) return a;
    r = start_row_cfg;
    c = start_col_cfg;
    visit_mark[cell_index(r, c)] = step_t'(1);
    for (guard = 0; guard < 2 * CELLS + 2; guard++) begin
      if (r == goal_row_cfg && c == goal_col_cfg) break;
      moved = 1'b0;
      for (d = 0; d < 4 && !moved; d++) begin
        if (passage_open(r, c, dir_e'(d), h, w)) begin
          step_toward(r, c, dir_e'(d), nr, nc);
          if (visit_mark[cell_index(nr, nc)] == '0) begin
            visit_mark[cell_index(nr, nc)] = (visit_mark[cell_index(r, c)] < STEP_MAX) ?
                visit_mark[cell_index(r, c)] + step_t'(1) : STEP_MAX;
            r = nr;
            c = nc;
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        dead_mark[cell_index(r, c)] = 1'b1;
        for (d = 0; d < 4 && !moved; d++) begin
          if (passage_open(r, c, dir_e'(d), h, w)) begin
            step_toward(r, c, dir_e'(d), nr, nc);
            if (!dead_mark[cell_index(nr, nc)]) begin
              r = nr;
              c = nc;
              moved = 1'b1;
            end
          end
        end
        if (!moved) break;
      end
    end
    walker_row_m = pos_t'(r);
    walker_col_m = pos_t'(c);
    a.step = visit_mark[cell_index(r, c)];
    a.goal = (r == goal_row_cfg && c == goal_col_cfg);
    return a;
  endfunction

  // Applies one accepted word to the local state and returns the answer owed.
  // Fields that mean nothing for an op stay zero.
  function automatic answer_t maze_answer(op_e op, pos_t row, pos_t col, logic [1:0] walls);
    answer_t a;
    int cell_idx;
    a = '0;
    cell_idx = cell_index(row, col);
    case (op)
      OP_WRITE: wall_mem[cell_idx] = walls;
      OP_RUN:   a = walk_toward_goal();
      OP_READ: begin
        a.step = visit_mark[cell_idx];
        a.dead = dead_mark[cell_idx];
      end
      default: ;
    endcase
    return a;
  endfunction

  // Offers one word and returns at the edge that accepts it. Valid stays high
  // afterward so back-to-back words never drop it; a gap lowers it first.
  task automatic send_word(op_e op, pos_t row, pos_t col, logic [1:0] walls);
    if (!calm && $urandom_range(0, 9) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= row;
    col_i      <= col;
    walls_i    <= walls;
    do @(posedge clk_i); while (!in_ready_o);
    answers_due.push_back(maze_answer(op, row, col, walls));
    if (op == OP_WRITE) wall_known[cell_index(row, col)] = 1'b1;
    words_sent++;
  endtask

  // Stops offering words and waits for every owed answer to come back.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 5'(value);
    @(posedge clk_i);
  endtask

  // Registers only change while the block is idle, so drain first.
  task automatic load_config(int h, int w, int sr, int sc, int gr, int gc);
    drain_answers();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_START_ROW, sr);
    write_reg(REG_START_COL, sc);
    write_reg(REG_GOAL_ROW, gr);
    write_reg(REG_GOAL_COL, gc);
    cfg_we_i <= 1'b0;
    rows_cfg      = h;
    cols_cfg      = w;
    start_row_cfg = sr;
    start_col_cfg = sc;
    goal_row_cfg  = gr;
    goal_col_cfg  = gc;
  endtask

  function automatic logic [1:0] random_walls(int density);
    return {$urandom_range(0, 99) < density, $urandom_range(0, 99) < density};
  endfunction

  // Writes every cell of the maze in use that was never written, plus a
  // random share of the others, so that no walk touches undefined walls.
  task automatic lay_walls(int density, int rewrite);
    int h, w;
    h = clamp_dim(rows_cfg, MAX_ROWS);
    w = clamp_dim(cols_cfg, MAX_COLS);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (!wall_known[cell_index(r, c)] || $urandom_range(0, 99) < rewrite) begin
          send_word(OP_WRITE, pos_t'(r), pos_t'(c), random_walls(density));
        end
      end
    end
  endtask

  // Marks after reset are all zero; unknown ops answer zeros and change nothing.
  task automatic test_idle_marks();
    send_word(OP_READ, 4'd0, 4'd0, 2'b11);
    send_word(OP_READ, 4'd15, 4'd15, 2'b00);
    send_word(OP_NONE, 4'd15, 4'd0, 2'b11);
    send_word(OP_NONE, 4'd0, 4'd15, 2'b00);
  endtask

  // A hand-built 3 by 3 maze with every wall combination, walked corner to corner.
  task automatic test_small_walk();
    load_config(3, 3, 0, 0, 2, 2);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_word(OP_WRITE, pos_t'(r), pos_t'(c), 2'((r * 3 + c) % 4));
      end
    end
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd1, 4'd1, 2'b00);
    send_word(OP_READ, 4'd2, 4'd2, 2'b00);
    send_word(OP_READ, 4'd0, 4'd2, 2'b00);
  endtask

  // Start on the goal: step 1 and the goal reached without moving.
  task automatic test_start_is_goal();
    load_config(3, 3, 1, 1, 1, 1);
    send_word(OP_RUN, 4'd15, 4'd15, 2'b11);
    send_word(OP_READ, 4'd1, 4'd1, 2'b00);
  endtask

  // Start outside the maze: marks are cleared and nothing else happens.
  task automatic test_start_outside();
    load_config(2, 2, 3, 0, 0, 0);
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd1, 4'd1, 2'b00);
  endtask

  // Goal outside the maze: the walk exhausts the maze and fails.
  task automatic test_goal_outside();
    load_config(3, 3, 0, 0, 15, 15);
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd2, 4'd2, 2'b00);
  endtask

  // Zero sizes count as one, sizes above 16 count as 16.
  task automatic test_size_clamp();
    load_config(0, 0, 0, 0, 0, 1);
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    load_config(31, 1, 0, 0, 15, 0);
    lay_walls(40, 0);
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd15, 4'd0, 2'b00);
    load_config(1, 31, 0, 15, 0, 0);
    lay_walls(20, 0);
    send_word(OP_RUN, 4'd0, 4'd0, 2'b00);
    send_word(OP_READ, 4'd0, 4'd7, 2'b00);
  endtask

  // Most sizes are small to keep walks short; a few are zero, full or above
  // the maximum.
  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 0;
    if (roll < 12) return $urandom_range(17, 31);
    if (roll < 72) return $urandom_range(1, 5);
    return $urandom_range(6, 16);
  endfunction

  // Mostly a cell inside the maze in use, now and then any cell at all.
  function automatic int pick_pos(int span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, span - 1);
  endfunction

  // Each phase sets a fresh configuration, lays a random maze of random wall
  // density, walks it once or twice and reads back marks. Stray reads,
  // unknown ops and wall writes anywhere make up the noise.
  task automatic test_random_mazes();
    int h, w, gr, gc, roll;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= WORD_TARGET - 100) calm = 1'b1;
      gap_odds   = $urandom_range(0, 4);
      stall_odds = $urandom_range(0, 4);
      h = pick_dim();
      w = pick_dim();
      gr = pick_pos(clamp_dim(h, MAX_ROWS));
      gc = pick_pos(clamp_dim(w, MAX_COLS));
      if ($urandom_range(0, 3) == 0) begin
        // Goal in the far corner gives the longest walks.
        gr = clamp_dim(h, MAX_ROWS) - 1;
        gc = clamp_dim(w, MAX_COLS) - 1;
      end
      load_config(h, w, pick_pos(clamp_dim(h, MAX_ROWS)), pick_pos(clamp_dim(w, MAX_COLS)),
                  gr, gc);
      lay_walls($urandom_range(0, 70), $urandom_range(0, 30));
      repeat ($urandom_range(1, 2)) begin
        send_word(OP_RUN, pos_t'($urandom_range(0, 15)), pos_t'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)));
        repeat ($urandom_range(2, 8)) begin
          roll = $urandom_range(0, 99);
          if (roll < 75) begin
            send_word(OP_READ, pos_t'($urandom_range(0, clamp_dim(h, MAX_ROWS) - 1)),
                      pos_t'($urandom_range(0, clamp_dim(w, MAX_COLS) - 1)),
                      2'($urandom_range(0, 3)));
          end else if (roll < 85) begin
            send_word(OP_READ, pos_t'($urandom_range(0, 15)), pos_t'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
          end else if (roll < 93) begin
            send_word(OP_NONE, pos_t'($urandom_range(0, 15)), pos_t'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
          end else begin
            send_word(OP_WRITE, pos_t'($urandom_range(0, 15)), pos_t'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
          end
        end
      end
    end
  endtask

  // The receiving side stalls in bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) < stall_odds) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every accepted result word is matched against the oldest answer owed.
  // Sampling at the edge sees the values the block itself acted on.
  always @(posedge clk_i) begin : check_words
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {step_number_o, dead_end_o, reached_goal_o};
      if (answers_due.size() == 0) begin
        if (fail_count < 10) begin
          $display("cycle %0d: result word with none owed: step %0d dead %0b goal %0b",
                   cycles, got.step, got.dead, got.goal);
        end
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (got.step !== want.step || got.dead !== want.dead || got.goal !== want.goal) begin
          if (fail_count < 10) begin
            $display("cycle %0d: expected step %0d dead %0b goal %0b, got step %0d dead %0b goal %0b",
                     cycles, want.step, want.dead, want.goal, got.step, got.dead, got.goal);
          end
          fail_count++;
        end
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_marks();
    test_small_walk();
    test_start_is_goal();
    test_start_outside();
    test_goal_outside();
    test_size_clamp();
    test_random_mazes();
    drain_answers();
    // Waiting on after the drain catches any stray result word.
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
